// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rotation block modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define IRN_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// concurrent assertion on the module clock and reset
`define IRN_ASSERT(lbl, prop) `IRN_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/core/irn_pkg.sv =====
// ----------------------------------------------------------------------------
// irn_pkg
// types, constants and helpers of the nearest-neighbor image rotation block
// ----------------------------------------------------------------------------
package irn_pkg;

  // frame store geometry
  localparam int MaxWidth  = 128;
  localparam int MaxHeight = 128;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int CoordW    = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = $clog2(Depth);

  // field widths
  localparam int PosW   = 7;
  localparam int DimW   = 8;
  localparam int TrigW  = 16;
  localparam int PixW   = 24;
  localparam int FracW  = 14;

  // datapath widths
  localparam int DeltaW = DimW + 2;
  localparam int ProdW  = TrigW + DeltaW;
  localparam int SumW   = ProdW + 2;
  localparam int IntW   = SumW - FracW - 1;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // queue depths
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH      = 3'd0,
    CFG_IMAGE_HEIGHT     = 3'd1,
    CFG_COS_ANGLE        = 3'd2,
    CFG_SIN_ANGLE        = 3'd3,
    CFG_BACKGROUND_COLOR = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2
  } kind_e;

  typedef struct packed {
    func_e             func;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [PixW-1:0]   pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            was_background;
  } out_item_t;

  // geometry and angle seen by the front end
  typedef struct packed {
    logic [DimW-1:0]         width;
    logic [DimW-1:0]         height;
    logic signed [TrigW-1:0] cos_angle;
    logic signed [TrigW-1:0] sin_angle;
  } cfg_t;

  // one classified operation for the frame store side
  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } q_entry_t;

  // zero reads as one, large values clamp to the store size
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] raw, int maxv);
    logic [DimW-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = DimW'(1);
    end else if (int'(raw) > maxv) begin
      d = DimW'(maxv);
    end
    return d;
  endfunction

  function automatic logic [AddrW-1:0] store_addr(logic [AddrW-1:0] col,
                                                  logic [AddrW-1:0] row);
    return AddrW'(row * AddrW'(MaxWidth)) + col;
  endfunction

endpackage

// ===== rtl/core/irn_queue.sv =====
// ----------------------------------------------------------------------------
// irn_queue
// short queue of classified operations between front end and frame store
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irn_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  irn_pkg::q_entry_t  entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output irn_pkg::q_entry_t  entry_o
);

  irn_pkg::q_entry_t             mem_q [irn_pkg::QDepth];
  logic [irn_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [irn_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [irn_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == irn_pkg::QCntW'(irn_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == irn_pkg::QPtrW'(irn_pkg::QDepth - 1)) ? '0
                                                                     : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == irn_pkg::QPtrW'(irn_pkg::QDepth - 1)) ? '0
                                                                     : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `IRN_ASSERT(a_q_no_overflow, push_i |-> !full_o)
  `IRN_ASSERT(a_q_no_underflow, pop_i |-> !empty_o)

endmodule

// ===== rtl/core/irn_front.sv =====
// ----------------------------------------------------------------------------
// irn_front
// accepts items, maps destination reads to source coordinates, classifies
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irn_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  irn_pkg::in_item_t  item_i,
  output logic               full_o,
  input  irn_pkg::cfg_t      cfg_i,
  output logic               q_push_o,
  output irn_pkg::q_entry_t  q_entry_o,
  input  logic               q_full_i
);

  localparam int PadW = irn_pkg::SumW - irn_pkg::DimW - irn_pkg::FracW;

  logic advance;
  logic accept;

  // stage 1: offsets from the center, write address
  logic                                s1_valid_q;
  irn_pkg::func_e                      s1_func_q;
  logic                                s1_inside_q;
  logic [irn_pkg::AddrW-1:0]           s1_addr_q;
  logic [irn_pkg::PixW-1:0]            s1_pix_q;
  logic signed [irn_pkg::DeltaW-1:0]   s1_dx2_q, s1_dy2_q;

  // stage 2: products
  logic                                s2_valid_q;
  irn_pkg::func_e                      s2_func_q;
  logic                                s2_inside_q;
  logic [irn_pkg::AddrW-1:0]           s2_addr_q;
  logic [irn_pkg::PixW-1:0]            s2_pix_q;
  logic signed [irn_pkg::ProdW-1:0]    s2_cx_q, s2_sy_q, s2_sx_q, s2_cy_q;

  // stage 3: rounded sums, biased by one half
  logic                                s3_valid_q;
  irn_pkg::func_e                      s3_func_q;
  logic                                s3_inside_q;
  logic [irn_pkg::AddrW-1:0]           s3_addr_q;
  logic [irn_pkg::PixW-1:0]            s3_pix_q;
  logic signed [irn_pkg::SumW-1:0]     s3_nu_q, s3_nv_q;

  logic [irn_pkg::DimW-1:0]            wm1, hm1;
  logic signed [irn_pkg::DeltaW-1:0]   dx2_d, dy2_d;
  logic signed [irn_pkg::SumW-1:0]     off_u, off_v, nu_d, nv_d;
  logic [irn_pkg::IntW-1:0]            u_int, v_int;
  logic                                bg;

  // whole pipe holds while the last stage waits on the queue
  assign advance = !(s3_valid_q && q_full_i);
  assign full_o  = !advance;
  assign accept  = push_i && advance;

  assign wm1   = cfg_i.width - irn_pkg::DimW'(1);
  assign hm1   = cfg_i.height - irn_pkg::DimW'(1);
  assign dx2_d = $signed(irn_pkg::DeltaW'({item_i.pos_x, 1'b0}) - irn_pkg::DeltaW'(wm1));
  assign dy2_d = $signed(irn_pkg::DeltaW'({item_i.pos_y, 1'b0}) - irn_pkg::DeltaW'(hm1));

  // center offset plus rounding half: (w-1)*2^14 + 2^14 = w*2^14
  assign off_u = $signed({{PadW{1'b0}}, cfg_i.width, {irn_pkg::FracW{1'b0}}});
  assign off_v = $signed({{PadW{1'b0}}, cfg_i.height, {irn_pkg::FracW{1'b0}}});
  assign nu_d  = irn_pkg::SumW'(s2_cx_q) + irn_pkg::SumW'(s2_sy_q) + off_u;
  assign nv_d  = irn_pkg::SumW'(s2_cy_q) - irn_pkg::SumW'(s2_sx_q) + off_v;

  // floor of biased sum over 2^15; non-positive means below zero
  assign u_int = s3_nu_q[irn_pkg::SumW-1:irn_pkg::FracW+1];
  assign v_int = s3_nv_q[irn_pkg::SumW-1:irn_pkg::FracW+1];
  assign bg    = s3_nu_q[irn_pkg::SumW-1] || (s3_nu_q == '0)
              || s3_nv_q[irn_pkg::SumW-1] || (s3_nv_q == '0)
              || (u_int >= irn_pkg::IntW'(cfg_i.width))
              || (v_int >= irn_pkg::IntW'(cfg_i.height));

  always_comb begin
    q_push_o       = 1'b0;
    q_entry_o.kind = irn_pkg::KIND_WRITE;
    q_entry_o.addr = s3_addr_q;
    q_entry_o.data = s3_pix_q;
    if (s3_func_q == irn_pkg::FUNC_WRITE) begin
      q_push_o = s3_valid_q && s3_inside_q && !q_full_i;
    end else begin
      q_push_o       = s3_valid_q && !q_full_i;
      q_entry_o.kind = bg ? irn_pkg::KIND_FILL : irn_pkg::KIND_READ;
      q_entry_o.addr = irn_pkg::store_addr(irn_pkg::AddrW'(u_int[irn_pkg::CoordW-1:0]),
                                           irn_pkg::AddrW'(v_int[irn_pkg::RowW-1:0]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_func_q   <= item_i.func;
      s1_inside_q <= (irn_pkg::DimW'(item_i.pos_x) < cfg_i.width)
                  && (irn_pkg::DimW'(item_i.pos_y) < cfg_i.height);
      s1_addr_q   <= irn_pkg::store_addr(irn_pkg::AddrW'(item_i.pos_x),
                                         irn_pkg::AddrW'(item_i.pos_y));
      s1_pix_q    <= item_i.pixel_in;
      s1_dx2_q    <= dx2_d;
      s1_dy2_q    <= dy2_d;

      s2_func_q   <= s1_func_q;
      s2_inside_q <= s1_inside_q;
      s2_addr_q   <= s1_addr_q;
      s2_pix_q    <= s1_pix_q;
      s2_cx_q     <= irn_pkg::ProdW'(cfg_i.cos_angle) * irn_pkg::ProdW'(s1_dx2_q);
      s2_sy_q     <= irn_pkg::ProdW'(cfg_i.sin_angle) * irn_pkg::ProdW'(s1_dy2_q);
      s2_sx_q     <= irn_pkg::ProdW'(cfg_i.sin_angle) * irn_pkg::ProdW'(s1_dx2_q);
      s2_cy_q     <= irn_pkg::ProdW'(cfg_i.cos_angle) * irn_pkg::ProdW'(s1_dy2_q);

      s3_func_q   <= s2_func_q;
      s3_inside_q <= s2_inside_q;
      s3_addr_q   <= s2_addr_q;
      s3_pix_q    <= s2_pix_q;
      s3_nu_q     <= nu_d;
      s3_nv_q     <= nv_d;
    end
  end

  `IRN_ASSERT(a_front_stall_holds,
              (s3_valid_q && q_full_i) |=> (s3_valid_q && $stable(s3_nu_q)))

endmodule

// ===== rtl/core/irn_back.sv =====
// ----------------------------------------------------------------------------
// irn_back
// frame store access and result queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irn_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  irn_pkg::q_entry_t         q_entry_i,
  output logic                      q_pop_o,
  input  logic [irn_pkg::PixW-1:0]  bg_color_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output irn_pkg::out_item_t        item_o
);

  logic [irn_pkg::PixW-1:0]     store_q [irn_pkg::Depth];
  logic [irn_pkg::PixW-1:0]     rd_q;
  logic                         r_valid_q;
  logic                         r_fill_q;
  logic                         room;

  irn_pkg::out_item_t           out_q [irn_pkg::OutDepth];
  irn_pkg::out_item_t           out_d;
  logic [irn_pkg::OutPtrW-1:0]  out_wr_q, out_rd_q;
  logic [irn_pkg::OutCntW-1:0]  out_cnt_q, out_cnt_d;
  logic                         out_pop;

  // a read leaves the queue only if its result has a slot reserved
  assign room = ((irn_pkg::OutCntW + 1)'(out_cnt_q) + (irn_pkg::OutCntW + 1)'(r_valid_q))
              < (irn_pkg::OutCntW + 1)'(irn_pkg::OutDepth);

  always_comb begin
    q_pop_o = 1'b0;
    if (!q_empty_i) begin
      unique case (q_entry_i.kind)
        irn_pkg::KIND_WRITE: q_pop_o = 1'b1;
        irn_pkg::KIND_READ,
        irn_pkg::KIND_FILL:  q_pop_o = room;
        default:             q_pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (q_entry_i.kind == irn_pkg::KIND_WRITE)) begin
      store_q[q_entry_i.addr] <= q_entry_i.data;
    end
    if (q_pop_o && (q_entry_i.kind == irn_pkg::KIND_READ)) begin
      rd_q <= store_q[q_entry_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      r_fill_q  <= 1'b0;
    end else begin
      r_valid_q <= q_pop_o && ((q_entry_i.kind == irn_pkg::KIND_READ)
                            || (q_entry_i.kind == irn_pkg::KIND_FILL));
      r_fill_q  <= (q_entry_i.kind == irn_pkg::KIND_FILL);
    end
  end

  // result queue
  assign out_d.pixel_out      = r_fill_q ? bg_color_i : rd_q;
  assign out_d.was_background = r_fill_q;
  assign empty_o              = (out_cnt_q == '0);
  assign out_pop              = pop_i && !empty_o;
  assign item_o               = out_q[out_rd_q];

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (r_valid_q && !out_pop) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (out_pop && !r_valid_q) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (r_valid_q) begin
        out_wr_q <= (out_wr_q == irn_pkg::OutPtrW'(irn_pkg::OutDepth - 1)) ? '0
                                                                            : out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= (out_rd_q == irn_pkg::OutPtrW'(irn_pkg::OutDepth - 1)) ? '0
                                                                            : out_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_valid_q) begin
      out_q[out_wr_q] <= out_d;
    end
  end

  `IRN_ASSERT(a_back_result_slot,
              r_valid_q |-> (out_cnt_q != irn_pkg::OutCntW'(irn_pkg::OutDepth)))

endmodule

// ===== rtl/core/image_rotate_nearest.sv =====
// a read passes the front-end stages, the operation queue, the store read register and the result queue
// throughput: one transaction per cycle while full is low, writes and reads mixed freely
// the single-port frame store takes one write or one read each cycle
// reset (rst_ni, async, active low): registers to defaults, queues empty
// frame store contents stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
// image_rotate_nearest
// nearest-neighbor rotation about the image center over a frame store
// ----------------------------------------------------------------------------
module image_rotate_nearest (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transaction side
  input  logic                           push,
  output logic                           full,
  input  irn_pkg::in_item_t              item_i,
  // result transaction side
  output logic                           empty,
  input  logic                           pop,
  output irn_pkg::out_item_t             item_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [irn_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [irn_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration state, dims stored already clamped to 1..max
  irn_pkg::cfg_t              cfg_q;
  logic [irn_pkg::PixW-1:0]   bg_q;

  // front to back queue
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  irn_pkg::q_entry_t          q_wr_entry;
  irn_pkg::q_entry_t          q_rd_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= irn_pkg::DimW'(irn_pkg::MaxWidth);
      cfg_q.height    <= irn_pkg::DimW'(irn_pkg::MaxHeight);
      cfg_q.cos_angle <= irn_pkg::TrigW'(16384);
      cfg_q.sin_angle <= '0;
      bg_q            <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irn_pkg::CFG_IMAGE_WIDTH: begin
          cfg_q.width <= irn_pkg::eff_dim(cfg_data_i[irn_pkg::DimW-1:0], irn_pkg::MaxWidth);
        end
        irn_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_q.height <= irn_pkg::eff_dim(cfg_data_i[irn_pkg::DimW-1:0], irn_pkg::MaxHeight);
        end
        irn_pkg::CFG_COS_ANGLE: begin
          cfg_q.cos_angle <= $signed(cfg_data_i[irn_pkg::TrigW-1:0]);
        end
        irn_pkg::CFG_SIN_ANGLE: begin
          cfg_q.sin_angle <= $signed(cfg_data_i[irn_pkg::TrigW-1:0]);
        end
        irn_pkg::CFG_BACKGROUND_COLOR: begin
          bg_q <= cfg_data_i[irn_pkg::PixW-1:0];
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // front end: coordinate mapping and classification, three stages
  irn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .cfg_i     (cfg_q),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry),
    .q_full_i  (q_full)
  );

  // decoupling queue so store side and front end stall independently
  irn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_rd_entry)
  );

  // back end: frame store access and result queue
  irn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_rd_entry),
    .q_pop_o    (q_pop),
    .bg_color_i (bg_q),
    .empty_o    (empty),
    .pop_i      (pop),
    .item_o     (item_o)
  );

endmodule
